>>> rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled during reset.
`define AVCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define AVCC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AVCC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/avcc_pkg.sv
package avcc_pkg;

  typedef enum logic [3:0] {
    PH_HEADER    = 4'd0,
    PH_SPS_LHI   = 4'd1,
    PH_SPS_LLO   = 4'd2,
    PH_SPS_PAY   = 4'd3,
    PH_PPS_COUNT = 4'd4,
    PH_PPS_LHI   = 4'd5,
    PH_PPS_LLO   = 4'd6,
    PH_PPS_PAY   = 4'd7,
    PH_DONE      = 4'd8
  } phase_e;

  localparam logic [2:0] ROLE_IGNORED = 3'd0;
  localparam logic [2:0] ROLE_HEADER  = 3'd1;
  localparam logic [2:0] ROLE_NALSIZE = 3'd2;
  localparam logic [2:0] ROLE_SPS_CNT = 3'd3;
  localparam logic [2:0] ROLE_LENGTH  = 3'd4;
  localparam logic [2:0] ROLE_SPS_PAY = 3'd5;
  localparam logic [2:0] ROLE_PPS_CNT = 3'd6;
  localparam logic [2:0] ROLE_PPS_PAY = 3'd7;

  localparam logic [1:0] STAT_BUSY  = 2'd0;
  localparam logic [1:0] STAT_DONE  = 2'd1;
  localparam logic [1:0] STAT_TRUNC = 2'd2;

  localparam logic [2:0] HDR_POS_NALSIZE = 3'd4;
  localparam logic [2:0] HDR_POS_SPS_CNT = 3'd5;
  localparam logic [7:0] NALSIZE_MASK    = 8'h03;
  localparam logic [7:0] SPS_CNT_MASK    = 8'h1F;

endpackage

>>> rtl/core/avcc_record_parser.sv
// AVC configuration record byte tagger.
// An accepted input byte's result is registered and shown on the master side in the next cycle.
// Throughput: one byte per cycle unless stalled; only the parse state and result register hold data.
// Input is taken while the result register is empty or being drained in the same cycle.
// Reset (rst_ni low, asynchronous) returns the parser to the header phase and drops m_axis_tvalid_o.
// After every byte flagged with tlast the parse state returns to its reset value.
module avcc_record_parser
  import avcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [7:0] field_value, [15:8] entry_index,
                                        // [17:16] parse_status, [22:18] sps_total,
                                        // [30:23] pps_total, [31] zero
  output logic [2:0]  m_axis_tuser_o,   // [2:0] byte_role
  output logic        m_axis_tlast_o    // entry_end
);

  `include "assert_macros.svh"

  phase_e      phase_q, phase_d;
  logic [2:0]  hdr_pos_q, hdr_pos_d;
  logic [7:0]  entries_left_q, entries_left_d;
  logic [7:0]  entry_cnt_q, entry_cnt_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] pay_left_q, pay_left_d;
  logic [4:0]  sps_seen_q, sps_seen_d;
  logic [7:0]  pps_seen_q, pps_seen_d;

  logic        out_valid_q;
  logic [2:0]  role_q, role_d;
  logic [7:0]  value_q, value_d;
  logic [7:0]  index_q, index_d;
  logic        end_q, end_d;
  logic [1:0]  status_q, status_d;
  logic [4:0]  sps_tot_q;
  logic [7:0]  pps_tot_q;

  logic        in_fire;
  logic        is_pps;
  logic [7:0]  b;
  logic [15:0] len_full;
  logic [15:0] pay_dec;
  logic [7:0]  sps_cnt;
  logic        last_entry;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign b          = s_axis_tdata_i;
  assign is_pps     = (phase_q == PH_PPS_LHI) || (phase_q == PH_PPS_LLO) ||
                      (phase_q == PH_PPS_PAY);
  assign len_full   = {len_hi_q, b};
  assign pay_dec    = pay_left_q - 16'd1;
  assign sps_cnt    = b & SPS_CNT_MASK;
  assign last_entry = (entries_left_q == 8'd1);

  always_comb begin
    phase_d        = phase_q;
    hdr_pos_d      = hdr_pos_q;
    entries_left_d = entries_left_q;
    entry_cnt_d    = entry_cnt_q;
    len_hi_d       = len_hi_q;
    pay_left_d     = pay_left_q;
    sps_seen_d     = sps_seen_q;
    pps_seen_d     = pps_seen_q;
    role_d         = ROLE_IGNORED;
    value_d        = b;
    index_d        = 8'd0;
    end_d          = 1'b0;

    case (phase_q)
      PH_HEADER: begin
        if (hdr_pos_q == HDR_POS_NALSIZE) begin
          role_d  = ROLE_NALSIZE;
          value_d = b & NALSIZE_MASK;
        end else if (hdr_pos_q >= HDR_POS_SPS_CNT) begin
          role_d         = ROLE_SPS_CNT;
          value_d        = sps_cnt;
          sps_seen_d     = sps_cnt[4:0];
          entries_left_d = sps_cnt;
          entry_cnt_d    = 8'd0;
          phase_d        = (sps_cnt == 8'd0) ? PH_PPS_COUNT : PH_SPS_LHI;
        end else begin
          role_d = ROLE_HEADER;
        end
        hdr_pos_d = hdr_pos_q + 3'd1;
      end
      PH_SPS_LHI, PH_PPS_LHI: begin
        role_d   = ROLE_LENGTH;
        index_d  = entry_cnt_q;
        len_hi_d = b;
        phase_d  = is_pps ? PH_PPS_LLO : PH_SPS_LLO;
      end
      PH_SPS_LLO, PH_PPS_LLO: begin
        role_d     = ROLE_LENGTH;
        index_d    = entry_cnt_q;
        pay_left_d = len_full;
        if (len_full == 16'd0) begin
          end_d          = 1'b1;
          entries_left_d = entries_left_q - 8'd1;
          entry_cnt_d    = entry_cnt_q + 8'd1;
          if (last_entry) begin
            phase_d = is_pps ? PH_DONE : PH_PPS_COUNT;
          end else begin
            phase_d = is_pps ? PH_PPS_LHI : PH_SPS_LHI;
          end
        end else begin
          phase_d = is_pps ? PH_PPS_PAY : PH_SPS_PAY;
        end
      end
      PH_SPS_PAY, PH_PPS_PAY: begin
        role_d     = is_pps ? ROLE_PPS_PAY : ROLE_SPS_PAY;
        index_d    = entry_cnt_q;
        pay_left_d = pay_dec;
        if (pay_dec == 16'd0) begin
          end_d          = 1'b1;
          entries_left_d = entries_left_q - 8'd1;
          entry_cnt_d    = entry_cnt_q + 8'd1;
          if (last_entry) begin
            phase_d = is_pps ? PH_DONE : PH_PPS_COUNT;
          end else begin
            phase_d = is_pps ? PH_PPS_LHI : PH_SPS_LHI;
          end
        end
      end
      PH_PPS_COUNT: begin
        role_d         = ROLE_PPS_CNT;
        pps_seen_d     = b;
        entries_left_d = b;
        entry_cnt_d    = 8'd0;
        phase_d        = (b == 8'd0) ? PH_DONE : PH_PPS_LHI;
      end
      default: begin
        phase_d = PH_DONE;
      end
    endcase

    if (phase_d == PH_DONE) begin
      status_d = STAT_DONE;
    end else if (s_axis_tlast_i) begin
      status_d = STAT_TRUNC;
    end else begin
      status_d = STAT_BUSY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_HEADER;
      hdr_pos_q      <= 3'd0;
      entries_left_q <= 8'd0;
      entry_cnt_q    <= 8'd0;
      len_hi_q       <= 8'd0;
      pay_left_q     <= 16'd0;
      sps_seen_q     <= 5'd0;
      pps_seen_q     <= 8'd0;
    end else if (in_fire) begin
      if (s_axis_tlast_i) begin
        phase_q        <= PH_HEADER;
        hdr_pos_q      <= 3'd0;
        entries_left_q <= 8'd0;
        entry_cnt_q    <= 8'd0;
        len_hi_q       <= 8'd0;
        pay_left_q     <= 16'd0;
        sps_seen_q     <= 5'd0;
        pps_seen_q     <= 8'd0;
      end else begin
        phase_q        <= phase_d;
        hdr_pos_q      <= hdr_pos_d;
        entries_left_q <= entries_left_d;
        entry_cnt_q    <= entry_cnt_d;
        len_hi_q       <= len_hi_d;
        pay_left_q     <= pay_left_d;
        sps_seen_q     <= sps_seen_d;
        pps_seen_q     <= pps_seen_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      role_q    <= role_d;
      value_q   <= value_d;
      index_q   <= index_d;
      end_q     <= end_d;
      status_q  <= status_d;
      sps_tot_q <= sps_seen_d;
      pps_tot_q <= pps_seen_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = role_q;
  assign m_axis_tlast_o  = end_q;
  assign m_axis_tdata_o  = {1'b0, pps_tot_q, sps_tot_q, status_q, index_q, value_q};

  `AVCC_ASSERT_NXT(a_rec_restart, in_fire && s_axis_tlast_i,
                   phase_q == PH_HEADER && hdr_pos_q == 3'd0 && entries_left_q == 8'd0,
                   "parser state not cleared after record end")
  `AVCC_ASSERT_IMP(a_end_role, m_axis_tvalid_o && m_axis_tlast_o,
                   role_q == ROLE_LENGTH || role_q == ROLE_SPS_PAY || role_q == ROLE_PPS_PAY,
                   "entry end on a byte outside an entry")
  `AVCC_ASSERT_IMP(a_index_role, m_axis_tvalid_o && index_q != 8'd0,
                   role_q == ROLE_LENGTH || role_q == ROLE_SPS_PAY || role_q == ROLE_PPS_PAY,
                   "entry index set on a byte outside an entry")
  `AVCC_ASSERT_IMP(a_list_count, phase_q == PH_SPS_LHI || phase_q == PH_PPS_LHI,
                   entries_left_q != 8'd0,
                   "entry phase with no entries left")

endmodule
